// ===== hw/rtl/ecmd_pkg.sv =====
// ---------------------------------------------------------------------------
// ecmd_pkg: shared types and constants of the event cell motion detector
// Holds the sensor geometry, table sizes, status codes and register indexes.
// ---------------------------------------------------------------------------
package ecmd_pkg;

  localparam int SensorWidth  = 640;
  localparam int SensorHeight = 480;
  localparam int MaxCells     = 8192;
  localparam int Pixels       = SensorWidth * SensorHeight;
  localparam int PixAw        = $clog2(Pixels);
  localparam int CellAw       = $clog2(MaxCells);

  // Event times are never negative, so a dead time that ends at zero never
  // blocks a cell; the dead time end is kept as an unsigned 49 bit value.
  localparam logic [48:0] LongAgo = 49'd0;

  typedef enum logic [1:0] {
    ST_NOISE   = 2'd0,
    ST_DEAD    = 2'd1,
    ST_COUNTED = 2'd2,
    ST_DETECT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CELL_SIZE  = 3'd0,
    REG_WINDOW     = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_DEAD       = 3'd3,
    REG_NEIGHBOUR  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [47:0] event_time;
  } event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  cell_col;
    logic [5:0]  cell_row;
    logic [15:0] window_count;
    logic [9:0]  out_x;
    logic [8:0]  out_y;
    logic [47:0] out_time;
  } result_t;

endpackage

// ===== hw/rtl/ecmd_if.sv =====
// ---------------------------------------------------------------------------
// ecmd_event_if / ecmd_result_if: valid/ready channels
// One word moves at a clock edge where valid and ready are both high.
// ---------------------------------------------------------------------------
interface ecmd_event_if;
  logic valid;
  logic ready;
  ecmd_pkg::event_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ecmd_result_if;
  logic valid;
  logic ready;
  ecmd_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ecmd_pixel_store.sv =====
// ---------------------------------------------------------------------------
// ecmd_pixel_store: per-pixel last-fire memory
// One read or write port; entries carry a valid bit cleared by a sweep.
// ---------------------------------------------------------------------------
module ecmd_pixel_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ecmd_pkg::PixAw-1:0] addr,
  input  logic [48:0]              wdata,
  output logic [48:0]              rdata
);
  logic [48:0] mem [ecmd_pkg::Pixels];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/ecmd_cell_store.sv =====
// ---------------------------------------------------------------------------
// ecmd_cell_store: per-cell window start, dead time end and count
// One address per cycle, registered read data.
// ---------------------------------------------------------------------------
module ecmd_cell_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ecmd_pkg::CellAw-1:0] addr,
  input  logic [112:0]              wdata,
  output logic [112:0]              rdata
);
  logic [112:0] mem [ecmd_pkg::MaxCells];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/event_cell_motion_detector_core.sv =====
// ---------------------------------------------------------------------------
// event_cell_motion_detector_core: event camera cell motion detector
// Optional noise filter over the 8 neighbours, then a per-cell tumbling counter.
// ---------------------------------------------------------------------------
// Usage: events (pixel_x, pixel_y, event_time) enter on evt; one result word
// per event leaves on res. Registers are written on cfg_we/cfg_index/cfg_data.
// The user must write them only while the block is idle; the block itself
// does not enforce this. After reset a clearing pass runs over the pixel
// memory and the cell memory (in the same pass); no event is taken then.
// The cell index is found by repeated subtraction, one cell column per
// cycle. With the filter on, each in-sensor neighbour is read and then
// compared, each off-sensor one is skipped, stopping at the first
// correlated one, followed by an end check and the own-pixel write. The cell
// read-modify-write runs through S_CELL_RD, S_CELL_WAIT, S_CELL_CMP and
// S_CELL_UPD, and the result is then loaded into the output register in
// S_OUT. After that load the block returns to S_IDLE, where a new event is
// taken; an event outside the sensor goes from S_IDLE straight to S_OUT.
// The output register holds a word while the next event is worked on; that
// event then waits, with evt.ready low, until the receiver takes the word.
// ---------------------------------------------------------------------------
module event_cell_motion_detector_core (
  input  logic        clk,
  input  logic        rst,
  ecmd_event_if.sink  evt,
  ecmd_result_if.source res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int PAw = ecmd_pkg::PixAw;
  localparam int CAw = ecmd_pkg::CellAw;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_NB_ADDR, S_NB_CMP, S_PIX_WR, S_CELL_RD,
    S_CELL_WAIT, S_CELL_CMP, S_CELL_UPD, S_OUT
  } state_t;

  state_t state;
  logic [6:0]  cell_size;
  logic [31:0] window_time;
  logic [15:0] count_threshold;
  logic [31:0] dead_time;
  logic [30:0] neighbour_time;

  ecmd_pkg::event_t ev;
  logic [6:0]  cs;
  logic [6:0]  ci;
  logic [5:0]  cj;
  logic [6:0]  nx;
  logic [3:0]  nb;
  logic        corr;
  logic [18:0] clr;
  logic [CAw-1:0] cell_addr;
  logic [15:0] need;
  ecmd_pkg::result_t rq;
  logic        ovalid;
  ecmd_pkg::result_t odata;

  logic        p_we;
  logic [PAw-1:0] p_addr;
  logic [48:0] p_wdata;
  logic [48:0] p_rdata;
  logic        c_we;
  logic [CAw-1:0] c_addr;
  logic [112:0] c_wdata;
  logic [112:0] c_rdata;

  // Neighbour offsets, centre skipped.
  logic signed [1:0] dx;
  logic signed [1:0] dy;
  logic signed [11:0] nxx;
  logic signed [10:0] nyy;
  logic        nb_in;
  logic [PAw-1:0] nb_addr;
  logic [PAw-1:0] own_addr;

  always_comb begin
    case (nb)
      4'd0: begin dx = -2'sd1; dy = -2'sd1; end
      4'd1: begin dx = 2'sd0;  dy = -2'sd1; end
      4'd2: begin dx = 2'sd1;  dy = -2'sd1; end
      4'd3: begin dx = -2'sd1; dy = 2'sd0;  end
      4'd4: begin dx = 2'sd1;  dy = 2'sd0;  end
      4'd5: begin dx = -2'sd1; dy = 2'sd1;  end
      4'd6: begin dx = 2'sd0;  dy = 2'sd1;  end
      default: begin dx = 2'sd1; dy = 2'sd1; end
    endcase
    nxx = $signed({2'b00, ev.pixel_x}) + 12'(dx);
    nyy = $signed({2'b00, ev.pixel_y}) + 11'(dy);
    nb_in = (nxx >= 0) && (nxx < 12'(ecmd_pkg::SensorWidth)) &&
            (nyy >= 0) && (nyy < 11'(ecmd_pkg::SensorHeight));
    nb_addr = PAw'(19'(nyy[8:0]) * 19'(ecmd_pkg::SensorWidth) + 19'(nxx[9:0]));
    own_addr = PAw'(19'(ev.pixel_y) * 19'(ecmd_pkg::SensorWidth) + 19'(ev.pixel_x));
  end

  // Cell record fields.
  logic [47:0] c_start;
  logic [48:0] c_dead;
  logic [15:0] c_cnt;
  assign c_start = c_rdata[112:65];
  assign c_dead  = c_rdata[64:16];
  assign c_cnt   = c_rdata[15:0];

  logic signed [49:0] tdiff;
  logic        in_dead;
  logic        restart;
  logic [15:0] cnt_new;
  logic signed [49:0] pdiff;
  assign tdiff   = $signed({2'b00, ev.event_time}) - $signed({2'b00, c_start});
  assign in_dead = {1'b0, ev.event_time} < c_dead;
  assign restart = (c_cnt == 16'd0) || (tdiff > $signed({18'd0, window_time}));
  assign cnt_new = (restart ? 16'd0 : c_cnt) + 16'd1;
  assign pdiff   = $signed({2'b00, ev.event_time}) - $signed({2'b00, p_rdata[47:0]});

  always_comb begin
    p_we = 1'b0;
    p_addr = nb_addr;
    p_wdata = {1'b1, ev.event_time};
    c_we = 1'b0;
    c_addr = cell_addr;
    c_wdata = c_rdata;
    if (state == S_CLEAR) begin
      p_we = 1'b1;
      p_addr = PAw'(clr);
      p_wdata = '0;
      c_we = 1'b1;
      c_addr = CAw'(clr);
      c_wdata = {48'd0, ecmd_pkg::LongAgo, 16'd0};
    end else if (state == S_PIX_WR) begin
      p_we = 1'b1;
      p_addr = own_addr;
    end else if (state == S_CELL_UPD) begin
      c_we = 1'b1;
      if (cnt_new < need) begin
        c_wdata = {(restart ? ev.event_time : c_start), c_dead, cnt_new};
      end else begin
        c_wdata = {ev.event_time,
                   49'({1'b0, ev.event_time} + {17'd0, dead_time}), 16'd0};
      end
    end
  end

  ecmd_pixel_store u_pix (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );

  ecmd_cell_store u_cell (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
  );

  assign evt.ready = (state == S_IDLE);
  assign res.valid = ovalid;
  assign res.data  = odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      ovalid <= 1'b0;
      cell_size <= 7'd16;
      window_time <= 32'd1000;
      count_threshold <= 16'd10;
      dead_time <= 32'd50000;
      neighbour_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ecmd_pkg::REG_CELL_SIZE: cell_size <= cfg_data[6:0];
          ecmd_pkg::REG_WINDOW:    window_time <= cfg_data;
          ecmd_pkg::REG_THRESHOLD: count_threshold <= cfg_data[15:0];
          ecmd_pkg::REG_DEAD:      dead_time <= cfg_data;
          ecmd_pkg::REG_NEIGHBOUR: neighbour_time <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!ovalid || res.ready)) begin
        ovalid <= 1'b1;
        odata <= rq;
      end else if (res.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 19'd1;
          if (clr == 19'(ecmd_pkg::Pixels - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (evt.valid) begin
            ev <= evt.data;
            rq <= '0;
            cs <= (cell_size < 7'd8) ? 7'd8 : ((cell_size > 7'd64) ? 7'd64 : cell_size);
            need <= (count_threshold == 16'd0) ? 16'd1 : count_threshold;
            ci <= '0;
            cj <= '0;
            nx <= '0;
            nb <= '0;
            corr <= 1'b0;
            if (evt.data.pixel_x >= 10'(ecmd_pkg::SensorWidth) ||
                evt.data.pixel_y >= 9'(ecmd_pkg::SensorHeight)) begin
              state <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Repeated subtraction: one cell column and one row per cycle.
          if (17'(ci) * 17'(cs) + 17'(cs) <= 17'(ev.pixel_x)) begin
            ci <= ci + 7'd1;
          end
          if (17'(cj) * 17'(cs) + 17'(cs) <= 17'(ev.pixel_y)) begin
            cj <= cj + 6'd1;
          end
          if (17'(nx) * 17'(cs) < 17'(ecmd_pkg::SensorWidth)) begin
            nx <= nx + 7'd1;
          end
          if (!(17'(ci) * 17'(cs) + 17'(cs) <= 17'(ev.pixel_x)) &&
              !(17'(cj) * 17'(cs) + 17'(cs) <= 17'(ev.pixel_y)) &&
              !(17'(nx) * 17'(cs) < 17'(ecmd_pkg::SensorWidth))) begin
            cell_addr <= CAw'(13'(cj) * 13'(nx) + 13'(ci));
            rq.cell_col <= ci;
            rq.cell_row <= cj;
            state <= (neighbour_time != 31'd0) ? S_NB_ADDR : S_CELL_RD;
          end
        end
        S_NB_ADDR: begin
          if (corr || nb == 4'd8) begin
            state <= S_PIX_WR;
          end else if (nb_in) begin
            state <= S_NB_CMP;
          end else begin
            nb <= nb + 4'd1;
          end
        end
        S_NB_CMP: begin
          if (p_rdata[48] && pdiff <= $signed({19'd0, neighbour_time})) begin
            corr <= 1'b1;
          end
          nb <= nb + 4'd1;
          state <= S_NB_ADDR;
        end
        S_PIX_WR: begin
          if (corr) begin
            state <= S_CELL_RD;
          end else begin
            rq.status <= ecmd_pkg::ST_NOISE;
            state <= S_OUT;
          end
        end
        S_CELL_RD: state <= S_CELL_WAIT;
        S_CELL_WAIT: state <= S_CELL_CMP;
        S_CELL_CMP: begin
          if (in_dead) begin
            rq.status <= ecmd_pkg::ST_DEAD;
            rq.window_count <= c_cnt;
            state <= S_OUT;
          end else begin
            state <= S_CELL_UPD;
          end
        end
        S_CELL_UPD: begin
          if (cnt_new < need) begin
            rq.status <= ecmd_pkg::ST_COUNTED;
            rq.window_count <= cnt_new;
          end else begin
            rq.status <= ecmd_pkg::ST_DETECT;
            rq.out_x <= ev.pixel_x;
            rq.out_y <= ev.pixel_y;
            rq.out_time <= ev.event_time;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/event_cell_motion_detector_core_test.sv =====
// ---------------------------------------------------------------------------
// event_cell_motion_detector_core_test: self-checking bench for the detector
// Drives pixel events with random bursts and gaps, stalls the result side,
// and checks every result word against a cycle-free model of the filter and
// the per-cell window, dead time and detection logic.
// ---------------------------------------------------------------------------
module event_cell_motion_detector_core_test;

  localparam longint LongAgoUs   = -64'sd1000000000000000;
  localparam int     CycleLimit  = 3000000;
  localparam int     DrainCycles = 40;
  localparam int     ExpDepth    = 4096;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  ecmd_event_if  evt ();
  ecmd_result_if res ();

  event_cell_motion_detector_core DUT (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state.
  longint      pix_time[int];
  longint      wstart_us[ecmd_pkg::MaxCells];
  longint      dead_end_us[ecmd_pkg::MaxCells];
  int unsigned cell_cnt[ecmd_pkg::MaxCells];
  int unsigned m_cell_size;
  longint      m_window;
  int unsigned m_threshold;
  longint      m_dead;
  longint      m_neighbour;

  // Expected words in send order; the sender writes exp_wr, the checker exp_rd.
  ecmd_pkg::result_t expected_words[ExpDepth];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          errors = 0;
  int          cycles = 0;
  int          n_sent;
  int          n_detect;
  int          n_noise;
  int          n_dead;
  int          n_cfg;
  bit          rx_hold;
  int          rx_pct = 100;
  int          burst_left;
  longint      now_us;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d words still expected", $time, exp_wr - exp_rd);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls at a changing rate; a hold forces ready low.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (cycles % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_pct = 100;
          1: rx_pct = 75;
          2: rx_pct = 40;
          default: rx_pct = 10;
        endcase
      end
      res.ready <= !rx_hold && ($urandom_range(1, 100) <= rx_pct);
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    ecmd_pkg::result_t e;
    ecmd_pkg::result_t a;
    if (!rst && res.valid && res.ready) begin
      a = res.data;
      if (exp_wr == exp_rd) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %h", $time, a);
      end else begin
        e = expected_words[exp_rd % ExpDepth];
        exp_rd++;
        check_field("status", e.status, a.status);
        check_field("cell_col", e.cell_col, a.cell_col);
        check_field("cell_row", e.cell_row, a.cell_row);
        check_field("window_count", e.window_count, a.window_count);
        check_field("out_x", e.out_x, a.out_x);
        check_field("out_y", e.out_y, a.out_y);
        check_field("out_time", e.out_time, a.out_time);
      end
    end
  end

  function automatic bit neighbour_fired(int x, int y, longint t);
    int k;
    for (int yy = (y > 0 ? y - 1 : 0);
         yy <= (y < ecmd_pkg::SensorHeight - 1 ? y + 1 : y); yy++) begin
      for (int xx = (x > 0 ? x - 1 : 0);
           xx <= (x < ecmd_pkg::SensorWidth - 1 ? x + 1 : x); xx++) begin
        k = yy * ecmd_pkg::SensorWidth + xx;
        if (!(xx == x && yy == y) && pix_time.exists(k) && (t - pix_time[k] <= m_neighbour))
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic ecmd_pkg::result_t classify_event(ecmd_pkg::event_t ev);
    ecmd_pkg::result_t r;
    int          x;
    int          y;
    longint      t;
    int unsigned cs;
    int unsigned need;
    int          ci;
    int          cj;
    int          nx;
    int          c;
    bit          corr;
    r = '0;
    x = ev.pixel_x;
    y = ev.pixel_y;
    t = longint'(ev.event_time);
    if (x >= ecmd_pkg::SensorWidth || y >= ecmd_pkg::SensorHeight) begin
      n_noise++;
      return r;
    end
    cs = m_cell_size < 8 ? 8 : (m_cell_size > 64 ? 64 : m_cell_size);
    need = m_threshold == 0 ? 1 : m_threshold;
    ci = x / cs;
    cj = y / cs;
    nx = (ecmd_pkg::SensorWidth + cs - 1) / cs;
    c = (cj * nx + ci) % ecmd_pkg::MaxCells;
    r.cell_col = 7'(ci);
    r.cell_row = 6'(cj);
    if (m_neighbour > 0) begin
      corr = neighbour_fired(x, y, t);
      pix_time[y * ecmd_pkg::SensorWidth + x] = t;
      if (!corr) begin
        n_noise++;
        return r;
      end
    end
    if (t < dead_end_us[c]) begin
      r.status = ecmd_pkg::ST_DEAD;
      r.window_count = 16'(cell_cnt[c]);
      n_dead++;
      return r;
    end
    if (cell_cnt[c] == 0 || t - wstart_us[c] > m_window) begin
      wstart_us[c] = t;
      cell_cnt[c] = 0;
    end
    cell_cnt[c] = (cell_cnt[c] + 1) & 16'hFFFF;
    if (cell_cnt[c] < need) begin
      r.status = ecmd_pkg::ST_COUNTED;
      r.window_count = 16'(cell_cnt[c]);
      return r;
    end
    dead_end_us[c] = t + m_dead;
    cell_cnt[c] = 0;
    wstart_us[c] = t;
    r.status = ecmd_pkg::ST_DETECT;
    r.out_x = 10'(x);
    r.out_y = 9'(y);
    r.out_time = ev.event_time;
    n_detect++;
    return r;
  endfunction

  // Offers one word and returns at the edge where it was taken.
  task automatic send_event(int x, int y, longint t);
    ecmd_pkg::event_t ev;
    ev.pixel_x = 10'(x);
    ev.pixel_y = 9'(y);
    ev.event_time = 48'(t);
    evt.valid <= 1'b1;
    evt.data <= ev;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    expected_words[exp_wr % ExpDepth] = classify_event(ev);
    exp_wr++;
    n_sent++;
  endtask

  // Burst/gap pacing around send_event.
  task automatic offer_event(int x, int y, longint t);
    send_event(x, y, t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic write_reg(ecmd_pkg::reg_idx_t idx, logic [31:0] value);
    evt.valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ecmd_pkg::REG_CELL_SIZE: m_cell_size = value[6:0];
      ecmd_pkg::REG_WINDOW:    m_window = longint'(value);
      ecmd_pkg::REG_THRESHOLD: m_threshold = value[15:0];
      ecmd_pkg::REG_DEAD:      m_dead = longint'(value);
      ecmd_pkg::REG_NEIGHBOUR: m_neighbour = longint'(value[30:0]);
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_all(int unsigned cs, logic [31:0] win, int unsigned thr,
                         logic [31:0] dead, logic [31:0] nb);
    write_reg(ecmd_pkg::REG_CELL_SIZE, cs);
    write_reg(ecmd_pkg::REG_WINDOW, win);
    write_reg(ecmd_pkg::REG_THRESHOLD, thr);
    write_reg(ecmd_pkg::REG_DEAD, dead);
    write_reg(ecmd_pkg::REG_NEIGHBOUR, nb);
  endtask

  // Reset values; corners, out-of-sensor pixels, a full count to detection.
  task automatic test_defaults;
    send_event(0, 0, 0);
    send_event(639, 479, 48'hFFFF_FFFF_FFFF);
    send_event(640, 10, 100);
    send_event(1023, 511, 48'hAAAA_5555_AAAA);
    send_event(5, 480, 200);
    for (int i = 0; i < 10; i++) send_event(20 + i, 20, 1000 + i);
    send_event(21, 21, 1200);
    send_event(339, 200, 48'h5555_AAAA_5555);
  endtask

  // Register extremes: saturated cell sizes, zero threshold, zero and full times.
  task automatic test_register_extremes;
    set_all(0, 0, 0, 0, 0);
    send_event(7, 7, 10);
    send_event(8, 8, 10);
    send_event(7, 7, 10);
    set_all(127, 32'hFFFF_FFFF, 2, 32'hFFFF_FFFF, 0);
    send_event(100, 100, 5);
    send_event(127, 127, 6);
    send_event(100, 100, 7);
    send_event(639, 479, 8);
    set_all(8, 3, 65535, 10, 0);
    send_event(3, 3, 100);
    send_event(3, 3, 104);
    send_event(3, 3, 90);
  endtask

  // Filter: never-fired neighbours, correlated, stale and out-of-order times.
  task automatic test_noise_filter;
    set_all(64, 1000, 3, 500, 32'hFFFF_FFFF);
    write_reg(ecmd_pkg::REG_NEIGHBOUR, 10);
    send_event(0, 0, 1000);
    send_event(1, 1, 1005);
    send_event(2, 2, 1100);
    send_event(1, 0, 1020);
    send_event(639, 479, 2000);
    send_event(638, 478, 1990);
    send_event(300, 300, 3000);
    send_event(301, 300, 3010);
    send_event(302, 300, 3021);
  endtask

  task automatic random_phase(int count);
    int hx;
    int hy;
    int x;
    int y;
    longint t;
    int unsigned r;
    hx = $urandom_range(0, ecmd_pkg::SensorWidth - 1);
    hy = $urandom_range(0, ecmd_pkg::SensorHeight - 1);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        hx = $urandom_range(0, ecmd_pkg::SensorWidth - 1);
        hy = $urandom_range(0, ecmd_pkg::SensorHeight - 1);
      end
      if (r >= 92) begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 511);
      end else begin
        x = hx + $urandom_range(0, 6) - 3;
        y = hy + $urandom_range(0, 6) - 3;
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        if (x >= ecmd_pkg::SensorWidth) x = ecmd_pkg::SensorWidth - 1;
        if (y >= ecmd_pkg::SensorHeight) y = ecmd_pkg::SensorHeight - 1;
      end
      now_us += $urandom_range(0, 40);
      t = now_us;
      if ($urandom_range(0, 99) < 4) t = {$urandom_range(0, 65535), $urandom()};
      else if ($urandom_range(0, 99) < 5) t = now_us - $urandom_range(0, 200);
      if (t < 0) t = 0;
      offer_event(x, y, t & 48'hFFFF_FFFF_FFFF);
    end
  endtask

  task automatic test_random_traffic;
    for (int p = 0; p < 13; p++) begin
      set_all($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(8, 64),
              $urandom_range(50, 3000), $urandom_range(0, 12), $urandom_range(0, 2000),
              $urandom_range(0, 1) ? 0 : $urandom_range(1, 400));
      random_phase(100);
    end
  endtask

  // A long receiver hold while words keep coming fills the block up.
  task automatic test_output_backpressure;
    set_all(16, 500, 4, 300, 0);
    rx_hold = 1'b1;
    fork
      repeat (400) @(posedge clk);
      random_phase(30);
    join_any
    rx_hold = 1'b0;
    wait fork;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ecmd_pkg::REG_CELL_SIZE;
    cfg_data = '0;
    evt.valid = 1'b0;
    evt.data = '0;
    rx_hold = 1'b0;
    burst_left = 0;
    now_us = 5000;
    n_sent = 0;
    n_detect = 0;
    n_noise = 0;
    n_dead = 0;
    n_cfg = 0;
    m_cell_size = 16;
    m_window = 1000;
    m_threshold = 10;
    m_dead = 50000;
    m_neighbour = 0;
    for (int i = 0; i < ecmd_pkg::MaxCells; i++) begin
      wstart_us[i] = 0;
      dead_end_us[i] = LongAgoUs;
      cell_cnt[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_register_extremes();
    test_noise_filter();
    test_output_backpressure();
    test_random_traffic();

    evt.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d events and %0d register writes: %0d detections, %0d in dead time,",
             n_sent, n_cfg, n_detect, n_dead);
    $display("%0d dropped as noise or outside the sensor, under random bursts and stalls.",
             n_noise);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
